@@ rtl/brpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brpc_pkg
// Shared types and constants of the binary relation property checker.
// ----------------------------------------------------------------------------
package brpc_pkg;

	// matrix geometry
	localparam int MAX_ELEMENTS = 32;
	localparam int ROW_W        = 32;
	localparam int IDX_W        = 5;
	localparam int N_W          = 6;
	localparam logic [N_W-1:0] SET_SIZE_RESET = N_W'(32);

	// stream payload layout
	localparam int IN_DATA_W  = 40;
	localparam int OUT_W      = 13;
	localparam int OUT_DATA_W = 16;

	localparam int B_REFL   = 0;
	localparam int B_AREFL  = 1;
	localparam int B_SYM    = 2;
	localparam int B_ASYM   = 3;
	localparam int B_TRANS  = 4;
	localparam int B_ATRANS = 5;
	localparam int B_TOTAL  = 6;
	localparam int B_TOL    = 7;
	localparam int B_EQUIV  = 8;
	localparam int B_ORDER  = 9;
	localparam int B_KIND   = 10;
	localparam int B_LINEAR = 12;

	// order kind codes
	localparam logic [1:0] KIND_NONE = 2'd0;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_DONE
	} state_t;

	// sequencer controls to the datapath
	typedef struct packed {
		logic             clear;
		logic             issue;
		logic [IDX_W-1:0] x;
		logic             finish;
	} ctl_t;

	// row stage: row x and column x, both masked to the set in use
	typedef struct packed {
		logic             v;
		logic [IDX_W-1:0] x;
		logic [ROW_W-1:0] rx;
		logic [ROW_W-1:0] col;
	} s1_t;

	// running pass/fail of the basic properties
	typedef struct packed {
		logic refl;
		logic arefl;
		logic sym;
		logic asym;
		logic trans;
		logic atrans;
		logic total;
	} flags_t;

endpackage
`default_nettype wire

@@ rtl/binary_relation_property_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// binary_relation_property_checker
// Loads a boolean relation matrix row by row and classifies the relation.
// ----------------------------------------------------------------------------
// Rows are taken one per cycle while the block is idle, one row per input
// transaction. A transaction with tlast stores its row and starts the
// evaluation; the input then stalls for the evaluation, and longer while an
// earlier result still waits to be taken. During the stall a row counter
// walks the rows in use (set_size capped at 32, none for an empty set), one
// row per cycle, with 32 lanes checking the composition against every row
// at once, before the result transaction appears on the output. The result
// register lets a new run of rows load while it waits to be taken.
// Rows in use must all be written before the row marked last; set_size must
// be written only while the block is idle, which the block does not enforce.
module binary_relation_property_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// configuration: set_size
	input  wire logic                               cfg_we,
	input  wire logic [brpc_pkg::N_W-1:0]           cfg_wdata,
	// rows in
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [brpc_pkg::IN_DATA_W-1:0]     s_tdata,  // row_index[4:0], row_bits[36:5]
	input  wire logic                               s_tlast,  // last_row
	// classification out
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// reflexive[0], irreflexive[1], symmetric[2], antisymmetric[3],
	// transitive[4], intransitive[5], total[6], tolerance[7],
	// equivalence[8], order[9], order_kind[11:10], linear_order[12]
	output logic [brpc_pkg::OUT_DATA_W-1:0]         m_tdata
);

	logic [brpc_pkg::ROW_W-1:0]        row_q [brpc_pkg::MAX_ELEMENTS];
	logic [brpc_pkg::N_W-1:0]          set_size_q;
	logic [brpc_pkg::N_W-1:0]          n;
	logic [brpc_pkg::ROW_W-1:0]        mask;
	logic [brpc_pkg::ROW_W-1:0]        col;
	logic [brpc_pkg::MAX_ELEMENTS-1:0] lane_trans, lane_atrans;
	logic                              in_acc, start, idle, merge_busy, out_free;
	brpc_pkg::ctl_t                    ctl;
	brpc_pkg::s1_t                     s1;

	assign in_acc   = s_tvalid & s_tready;
	assign start    = in_acc & s_tlast;
	assign s_tready = idle;
	assign out_free = ~m_tvalid | m_tready;

	// set size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_size_q <= brpc_pkg::SET_SIZE_RESET;
		end else if (cfg_we) begin
			set_size_q <= cfg_wdata;
		end
	end

	// effective size and the mask of columns in use
	always_comb begin
		n    = (set_size_q > brpc_pkg::N_W'(brpc_pkg::MAX_ELEMENTS)) ?
		       brpc_pkg::N_W'(brpc_pkg::MAX_ELEMENTS) : set_size_q;
		mask = (n >= brpc_pkg::N_W'(brpc_pkg::ROW_W)) ? '1 :
		       ((brpc_pkg::ROW_W'(1) << n) - brpc_pkg::ROW_W'(1));
	end

	// matrix store, every row index addresses a row
	always_ff @(posedge clk) begin
		if (in_acc) begin
			row_q[s_tdata[brpc_pkg::IDX_W-1:0]] <= s_tdata[brpc_pkg::IDX_W +: brpc_pkg::ROW_W];
		end
	end

	// column x gathered from every row
	always_comb begin
		for (int z = 0; z < brpc_pkg::MAX_ELEMENTS; z++) begin
			col[z] = row_q[z][ctl.x];
		end
	end

	// row stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1 <= '0;
		end else begin
			s1.v <= ctl.issue;
			if (ctl.issue) begin
				s1.x   <= ctl.x;
				s1.rx  <= row_q[ctl.x] & mask;
				s1.col <= col & mask;
			end
		end
	end

	brpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.n         (n),
		.pipe_busy (s1.v | merge_busy),
		.out_free  (out_free),
		.ctl       (ctl),
		.idle      (idle)
	);

	// composition lanes, one per row z
	for (genvar z = 0; z < brpc_pkg::MAX_ELEMENTS; z++) begin : g_lane
		brpc_lane u_lane (
			.row_z       (row_q[z]),
			.row_x       (s1.rx),
			.mask        (mask),
			.sel         (s1.rx[z]),
			.trans_fail  (lane_trans[z]),
			.atrans_fail (lane_atrans[z])
		);
	end

	brpc_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.s1          (s1),
		.mask        (mask),
		.lane_trans  (lane_trans),
		.lane_atrans (lane_atrans),
		.m_tready    (m_tready),
		.m_tvalid    (m_tvalid),
		.m_tdata     (m_tdata),
		.busy        (merge_busy)
	);

endmodule
`default_nettype wire

@@ rtl/brpc_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brpc_lane
// One composition lane: checks row z against row x when (x, z) is present.
// ----------------------------------------------------------------------------
module brpc_lane (
	input  wire logic [brpc_pkg::ROW_W-1:0] row_z,
	input  wire logic [brpc_pkg::ROW_W-1:0] row_x,
	input  wire logic [brpc_pkg::ROW_W-1:0] mask,
	input  wire logic                       sel,
	output logic                            trans_fail,
	output logic                            atrans_fail
);

	logic [brpc_pkg::ROW_W-1:0] rz;

	// (x,z) and (z,y) with (x,y) absent breaks transitivity, present breaks antitransitivity
	always_comb begin
		rz          = row_z & mask;
		trans_fail  = sel & (|(rz & ~row_x));
		atrans_fail = sel & (|(rz & row_x));
	end

endmodule
`default_nettype wire

@@ rtl/brpc_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brpc_ctrl
// Evaluation sequencer: walks the rows in use and hands off the result.
// ----------------------------------------------------------------------------
module brpc_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [brpc_pkg::N_W-1:0]  n,
	input  wire logic                      pipe_busy,
	input  wire logic                      out_free,
	output brpc_pkg::ctl_t                 ctl,
	output logic                           idle
);

	brpc_pkg::state_t              state_q, state_d;
	logic [brpc_pkg::IDX_W-1:0]    x_q;
	logic                          last_x;

	assign last_x = ({1'b0, x_q} == (n - brpc_pkg::N_W'(1)));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			brpc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = (n == '0) ? brpc_pkg::ST_FLUSH : brpc_pkg::ST_SCAN;
				end
			end
			brpc_pkg::ST_SCAN: begin
				if (last_x) begin
					state_d = brpc_pkg::ST_FLUSH;
				end
			end
			brpc_pkg::ST_FLUSH: begin
				if (!pipe_busy) begin
					state_d = brpc_pkg::ST_DONE;
				end
			end
			brpc_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = brpc_pkg::ST_IDLE;
				end
			end
			default: state_d = brpc_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		ctl.clear  = 1'b0;
		ctl.issue  = 1'b0;
		ctl.x      = x_q;
		ctl.finish = 1'b0;
		idle       = 1'b0;
		case (state_q)
			brpc_pkg::ST_IDLE: begin
				idle      = 1'b1;
				ctl.clear = start;
			end
			brpc_pkg::ST_SCAN:  ctl.issue  = 1'b1;
			brpc_pkg::ST_FLUSH: ctl.issue  = 1'b0;
			brpc_pkg::ST_DONE:  ctl.finish = out_free;
			default:            idle       = 1'b0;
		endcase
	end

	// state and row counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= brpc_pkg::ST_IDLE;
			x_q     <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.clear) begin
				x_q <= '0;
			end else if (ctl.issue) begin
				x_q <= x_q + brpc_pkg::IDX_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

@@ rtl/brpc_merge.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brpc_merge
// Merging stage: folds lane and row checks into the property flags and
// holds the result transaction.
// ----------------------------------------------------------------------------
module brpc_merge (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire brpc_pkg::ctl_t                    ctl,
	input  wire brpc_pkg::s1_t                     s1,
	input  wire logic [brpc_pkg::ROW_W-1:0]        mask,
	input  wire logic [brpc_pkg::MAX_ELEMENTS-1:0] lane_trans,
	input  wire logic [brpc_pkg::MAX_ELEMENTS-1:0] lane_atrans,
	input  wire logic                              m_tready,
	output logic                                   m_tvalid,
	output logic [brpc_pkg::OUT_DATA_W-1:0]        m_tdata,
	output logic                                   busy
);

	logic                                  v_s2;
	logic                                  diag_s2, sym_fail_s2, asym_fail_s2, total_fail_s2;
	logic [brpc_pkg::MAX_ELEMENTS-1:0]     trans_s2, atrans_s2;
	logic [brpc_pkg::ROW_W-1:0]            off_diag;
	brpc_pkg::flags_t                      acc_q;
	logic [brpc_pkg::OUT_W-1:0]            out_q;
	logic [brpc_pkg::OUT_W-1:0]            res;
	logic                                  m_tvalid_q;
	logic                                  tol, equiv, order;

	assign off_diag = mask & ~(brpc_pkg::ROW_W'(1) << s1.x);
	assign busy     = v_s2;

	// row checks against column x, and lane results, registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= s1.v;
		end
	end

	always_ff @(posedge clk) begin
		diag_s2       <= s1.rx[s1.x];
		sym_fail_s2   <= |(s1.rx & ~s1.col & mask);
		asym_fail_s2  <= |(s1.rx & s1.col & off_diag);
		total_fail_s2 <= |(~s1.rx & ~s1.col & off_diag);
		trans_s2      <= lane_trans;
		atrans_s2     <= lane_atrans;
	end

	// property accumulators
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '1;
		end else if (v_s2) begin
			acc_q.refl   <= acc_q.refl & diag_s2;
			acc_q.arefl  <= acc_q.arefl & ~diag_s2;
			acc_q.sym    <= acc_q.sym & ~sym_fail_s2;
			acc_q.asym   <= acc_q.asym & ~asym_fail_s2;
			acc_q.trans  <= acc_q.trans & ~(|trans_s2);
			acc_q.atrans <= acc_q.atrans & ~(|atrans_s2);
			acc_q.total  <= acc_q.total & ~total_fail_s2;
		end
	end

	// derived properties
	always_comb begin
		tol   = acc_q.refl & acc_q.sym;
		equiv = tol & acc_q.trans;
		order = acc_q.asym & acc_q.trans;
		res                    = '0;
		res[brpc_pkg::B_REFL]   = acc_q.refl;
		res[brpc_pkg::B_AREFL]  = acc_q.arefl;
		res[brpc_pkg::B_SYM]    = acc_q.sym;
		res[brpc_pkg::B_ASYM]   = acc_q.asym;
		res[brpc_pkg::B_TRANS]  = acc_q.trans;
		res[brpc_pkg::B_ATRANS] = acc_q.atrans;
		res[brpc_pkg::B_TOTAL]  = acc_q.total;
		res[brpc_pkg::B_TOL]    = tol;
		res[brpc_pkg::B_EQUIV]  = equiv;
		res[brpc_pkg::B_ORDER]  = order;
		res[brpc_pkg::B_KIND +: 2] = order ? {acc_q.arefl, acc_q.refl} : brpc_pkg::KIND_NONE;
		res[brpc_pkg::B_LINEAR] = order & acc_q.total;
	end

	// result transaction register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctl.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(brpc_pkg::OUT_DATA_W - brpc_pkg::OUT_W){1'b0}}, out_q};

endmodule
`default_nettype wire

@@ rtl/brpc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// brpc_checker
// Port-level checks of the relation property checker, bound to the top level.
// ----------------------------------------------------------------------------
module brpc_checker (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic                               s_tlast,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [brpc_pkg::OUT_DATA_W-1:0]    m_tdata
);

	// a waiting result transaction holds its data
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// the last row starts an evaluation, which stalls the input
	a_eval_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("input taken during evaluation");

	// derived properties agree with the basic ones
	a_derived: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
		(m_tdata[brpc_pkg::B_TOL] == (m_tdata[brpc_pkg::B_REFL] && m_tdata[brpc_pkg::B_SYM])) &&
		(m_tdata[brpc_pkg::B_EQUIV] == (m_tdata[brpc_pkg::B_TOL] && m_tdata[brpc_pkg::B_TRANS])) &&
		(m_tdata[brpc_pkg::B_ORDER] == (m_tdata[brpc_pkg::B_ASYM] && m_tdata[brpc_pkg::B_TRANS])) &&
		(m_tdata[brpc_pkg::B_LINEAR] == (m_tdata[brpc_pkg::B_ORDER] && m_tdata[brpc_pkg::B_TOTAL])))
		else $error("derived property mismatch");

	// order kind follows the diagonal properties of an order
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
		(m_tdata[brpc_pkg::B_KIND +: 2] == (m_tdata[brpc_pkg::B_ORDER] ?
			{m_tdata[brpc_pkg::B_AREFL], m_tdata[brpc_pkg::B_REFL]} : brpc_pkg::KIND_NONE)))
		else $error("order kind mismatch");

endmodule

bind binary_relation_property_checker brpc_checker u_brpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tlast  (s_tlast),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

@@ tb/binary_relation_property_checker_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_relation_property_checker_tb
// Streams relation matrices into the checker one row per transaction and
// compares every classification against a behavioral predictor that keeps
// its own copy of the matrix and of set_size. Covers the empty set, single
// and small sets, shaped relations (equivalences, orders, bipartite, total)
// with stray bits above the set, random stalls on both sides, a long output
// hold-off and drain pauses.
// ----------------------------------------------------------------------------
module binary_relation_property_checker_tb;

	localparam int CLK_HALF       = 10;
	localparam int SETTLE_CYCLES  = 50;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 400;
	localparam int RANDOM_ROWS    = 1300;
	localparam int PHASE_ROWS     = 90;
	localparam int MAX_REPORTS    = 10;

	localparam logic [1:0] KIND_STRICT    = 2'd2;
	localparam logic [brpc_pkg::IDX_W-1:0] TOP_ROW =
		brpc_pkg::IDX_W'(brpc_pkg::MAX_ELEMENTS - 1);

	// one classification, lowest bit is the reflexive flag
	typedef struct packed {
		logic       linear;
		logic [1:0] kind;
		logic       order;
		logic       equiv;
		logic       tol;
		logic       total;
		logic       atrans;
		logic       trans;
		logic       asym;
		logic       sym;
		logic       arefl;
		logic       refl;
	} verdict_t;

	// shapes of generated relations
	typedef enum int {
		REL_RANDOM,
		REL_EQUIV,
		REL_LINEAR,
		REL_PARTIAL,
		REL_BIPARTITE,
		REL_SYMMETRIC,
		REL_TOURNAMENT,
		REL_SHAPES
	} rel_shape_t;

	logic                            clk       = 1'b0;
	logic                            arst_n    = 1'b0;
	logic                            cfg_we    = 1'b0;
	logic [brpc_pkg::N_W-1:0]        cfg_wdata = '0;
	logic                            s_tvalid  = 1'b0;
	logic                            s_tready;
	logic [brpc_pkg::IN_DATA_W-1:0]  s_tdata   = '0;  // row_index[4:0], row_bits[36:5]
	logic                            s_tlast   = 1'b0; // last_row
	logic                            m_tvalid;
	logic                            m_tready  = 1'b0;
	logic [brpc_pkg::OUT_DATA_W-1:0] m_tdata;  // verdict_t fields, reflexive flag at bit 0

	// predictor state
	logic [brpc_pkg::ROW_W-1:0]        model_rows [brpc_pkg::MAX_ELEMENTS];
	logic [brpc_pkg::N_W-1:0]          model_size = brpc_pkg::SET_SIZE_RESET;
	logic [brpc_pkg::MAX_ELEMENTS-1:0] rows_written = '0;
	verdict_t                          pending_verdicts [$];

	// relation being built for the next frame
	logic [brpc_pkg::ROW_W-1:0] frame_rows [brpc_pkg::MAX_ELEMENTS];
	int                         order_rank [brpc_pkg::MAX_ELEMENTS];

	bit no_idle  = 1'b0;
	bit hold_req = 1'b0;

	int errors           = 0;
	int rows_sent        = 0;
	int verdicts_checked = 0;
	int seen_equiv       = 0;
	int seen_linear      = 0;
	int seen_strict      = 0;
	int seen_atrans      = 0;

	binary_relation_property_checker DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [brpc_pkg::ROW_W-1:0] size_mask(input int n);
		if (n >= brpc_pkg::ROW_W)
			return '1;
		return (brpc_pkg::ROW_W'(1) << n) - brpc_pkg::ROW_W'(1);
	endfunction

	// classify the predictor's matrix under the current set size
	function automatic verdict_t classify_relation();
		verdict_t                   v;
		int                         n, x, y, z;
		logic [brpc_pkg::ROW_W-1:0] mask, rx, rz;
		logic                       xy, yx;
		logic                       refl, arefl, sym, asym, trans, atrans, total;
		n = int'(model_size);
		if (n > brpc_pkg::MAX_ELEMENTS)
			n = brpc_pkg::MAX_ELEMENTS;
		mask = size_mask(n);
		refl = 1'b1; arefl = 1'b1; sym = 1'b1; asym = 1'b1;
		trans = 1'b1; atrans = 1'b1; total = 1'b1;
		for (x = 0; x < n; x++) begin
			rx = model_rows[x] & mask;
			if (rx[x])
				arefl = 1'b0;
			else
				refl = 1'b0;
			for (y = 0; y < n; y++) begin
				xy = rx[y];
				yx = model_rows[y][x];
				if (xy && !yx)
					sym = 1'b0;
				if (x != y) begin
					if (xy && yx)
						asym = 1'b0;
					if (!xy && !yx)
						total = 1'b0;
				end
			end
			// composition through every z related to x
			for (z = 0; z < n; z++) begin
				if (rx[z]) begin
					rz = model_rows[z] & mask;
					if ((rz & ~rx) != '0)
						trans = 1'b0;
					if ((rz & rx) != '0)
						atrans = 1'b0;
				end
			end
		end
		v.refl   = refl;
		v.arefl  = arefl;
		v.sym    = sym;
		v.asym   = asym;
		v.trans  = trans;
		v.atrans = atrans;
		v.total  = total;
		v.tol    = refl && sym;
		v.equiv  = v.tol && trans;
		v.order  = asym && trans;
		v.kind   = v.order ? {arefl, refl} : brpc_pkg::KIND_NONE;
		v.linear = v.order && total;
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// one row transaction, predictor updated on acceptance
	task automatic send_row(input logic [brpc_pkg::IDX_W-1:0] idx,
			input logic [brpc_pkg::ROW_W-1:0] bits, input logic last);
		int gap;
		s_tdata  = brpc_pkg::IN_DATA_W'({bits, idx});
		s_tlast  = last;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		model_rows[idx]   = bits;
		rows_written[idx] = 1'b1;
		rows_sent++;
		if (last)
			pending_verdicts.push_back(classify_relation());
		@(negedge clk);
		s_tvalid = 1'b0;
		gap = pick_gap();
		repeat (gap) @(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// set_size changes only with the block idle
	task automatic write_set_size(input int n);
		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wdata = brpc_pkg::N_W'(n);
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we     = 1'b0;
		model_size = brpc_pkg::N_W'(n);
	endtask

	// build a shaped relation on n elements, plus stray bits above the set
	task automatic make_relation(input int n);
		int                         shape, diag, density, classes, x, y, k, tmp, r;
		int                         cls [brpc_pkg::MAX_ELEMENTS];
		logic [brpc_pkg::ROW_W-1:0] side, mask;
		shape = $urandom_range(0, REL_SHAPES - 1);
		diag  = $urandom_range(0, 2);
		for (x = 0; x < brpc_pkg::MAX_ELEMENTS; x++) begin
			frame_rows[x] = '0;
			order_rank[x] = x;
		end
		for (x = n - 1; x > 0; x--) begin
			k = $urandom_range(0, x);
			tmp = order_rank[x];
			order_rank[x] = order_rank[k];
			order_rank[k] = tmp;
		end
		case (shape)
			REL_RANDOM: begin
				density = $urandom_range(0, 4);
				for (x = 0; x < n; x++)
					for (y = 0; y < n; y++)
						frame_rows[x][y] = ($urandom_range(0, 3) < density);
			end
			REL_EQUIV: begin
				classes = $urandom_range(1, n);
				for (x = 0; x < n; x++)
					cls[x] = $urandom_range(0, classes - 1);
				for (x = 0; x < n; x++)
					for (y = 0; y < n; y++)
						frame_rows[x][y] = (cls[x] == cls[y]);
			end
			REL_LINEAR: begin
				for (x = 0; x < n; x++)
					for (y = 0; y < n; y++)
						frame_rows[x][y] = (order_rank[x] < order_rank[y]);
			end
			REL_PARTIAL: begin
				for (x = 0; x < n; x++)
					for (y = 0; y < n; y++)
						frame_rows[x][y] = (order_rank[x] < order_rank[y]) &&
							($urandom_range(0, 2) == 0);
				// transitive closure
				for (k = 0; k < n; k++)
					for (x = 0; x < n; x++)
						if (frame_rows[x][k])
							frame_rows[x] |= frame_rows[k];
			end
			REL_BIPARTITE: begin
				side = $urandom;
				for (x = 0; x < n; x++)
					for (y = 0; y < n; y++)
						frame_rows[x][y] = !side[x] && side[y] && ($urandom_range(0, 1) == 1);
			end
			REL_SYMMETRIC: begin
				for (x = 0; x < n; x++)
					for (y = x + 1; y < n; y++) begin
						frame_rows[x][y] = ($urandom_range(0, 2) == 0);
						frame_rows[y][x] = frame_rows[x][y];
					end
			end
			default: begin
				// tournament, now and then a pair in both directions
				for (x = 0; x < n; x++)
					for (y = x + 1; y < n; y++) begin
						r = $urandom_range(0, 5);
						frame_rows[x][y] = (r < 3) || (r == 5);
						frame_rows[y][x] = (r >= 3);
					end
			end
		endcase
		// diagonal for the shapes that leave it open
		if (shape == REL_LINEAR || shape == REL_PARTIAL || shape == REL_SYMMETRIC ||
				shape == REL_TOURNAMENT)
			for (x = 0; x < n; x++)
				frame_rows[x][x] = (diag == 1) || (diag == 2 && $urandom_range(0, 1) == 1);
		// occasional single flipped pair breaks the shape
		if (n > 0 && $urandom_range(0, 3) == 0) begin
			x = $urandom_range(0, n - 1);
			y = $urandom_range(0, n - 1);
			frame_rows[x][y] = !frame_rows[x][y];
		end
		mask = size_mask(n);
		for (x = 0; x < brpc_pkg::MAX_ELEMENTS; x++)
			if ($urandom_range(0, 1) == 1)
				frame_rows[x] |= $urandom & ~mask;
	endtask

	// every row in use, in random order, the last one marked
	task automatic send_frame(input int n);
		int i;
		make_relation(n);
		for (i = 0; i < n; i++)
			send_row(brpc_pkg::IDX_W'(order_rank[i]), frame_rows[order_rank[i]], i == n - 1);
	endtask

	// some rows rewritten, then a marked row that may lie outside the set
	task automatic send_partial_frame(input int n);
		int i, count, idx;
		make_relation(n);
		count = $urandom_range(0, n);
		for (i = 0; i < count; i++) begin
			idx = $urandom_range(0, n - 1);
			send_row(brpc_pkg::IDX_W'(idx), frame_rows[idx], 1'b0);
		end
		idx = $urandom_range(0, brpc_pkg::MAX_ELEMENTS - 1);
		send_row(brpc_pkg::IDX_W'(idx),
			(idx < n) ? frame_rows[idx] : brpc_pkg::ROW_W'($urandom), 1'b1);
	endtask

	task automatic test_empty_set();
		write_set_size(0);
		send_row(TOP_ROW, '1, 1'b1);
	endtask

	task automatic test_single_element();
		write_set_size(1);
		send_row('0, '1, 1'b1);
		send_row('0, 32'hFFFF_FFFE, 1'b1);
		send_row(TOP_ROW, '0, 1'b1);
	endtask

	// order that is neither reflexive nor antireflexive
	task automatic test_pair_extremes();
		write_set_size(2);
		send_row('0, '0, 1'b0);
		send_row(brpc_pkg::IDX_W'(1), '1, 1'b1);
	endtask

	task automatic test_three_element_shapes();
		write_set_size(3);
		// strict chain, stray bits above the set on row 1
		send_row(brpc_pkg::IDX_W'(0), 32'h0000_0006, 1'b0);
		send_row(brpc_pkg::IDX_W'(1), 32'hFFFF_FFFC, 1'b0);
		send_row(brpc_pkg::IDX_W'(2), 32'h0000_0000, 1'b1);
		// equivalence with two classes
		send_row(brpc_pkg::IDX_W'(0), 32'h0000_0003, 1'b0);
		send_row(brpc_pkg::IDX_W'(1), 32'h0000_0003, 1'b0);
		send_row(brpc_pkg::IDX_W'(2), 32'h0000_0004, 1'b1);
		// one source, two sinks
		send_row(brpc_pkg::IDX_W'(0), 32'h0000_0006, 1'b0);
		send_row(brpc_pkg::IDX_W'(1), 32'h0000_0000, 1'b0);
		send_row(brpc_pkg::IDX_W'(2), 32'h0000_0000, 1'b1);
		// directed cycle through all three elements
		send_row(brpc_pkg::IDX_W'(0), 32'h0000_0002, 1'b0);
		send_row(brpc_pkg::IDX_W'(1), 32'h0000_0004, 1'b0);
		send_row(brpc_pkg::IDX_W'(2), 32'h0000_0001, 1'b1);
	endtask

	// output held off while frames keep coming, then a full drain
	task automatic test_output_stall();
		write_set_size(4);
		no_idle  = 1'b1;
		hold_req = 1'b1;
		repeat (6) send_frame(4);
		no_idle = 1'b0;
		wait_drained();
		send_frame(4);
	endtask

	task automatic test_random_frames();
		int phase, n, r, start_rows, phase_rows;
		phase = 0;
		start_rows = rows_sent;
		while (rows_sent - start_rows < RANDOM_ROWS) begin
			r = $urandom_range(0, 99);
			if (phase == 0)
				n = brpc_pkg::MAX_ELEMENTS;
			else if (phase == 1)
				n = 1;
			else if (r < 60)
				n = $urandom_range(2, 8);
			else if (r < 85)
				n = $urandom_range(9, 16);
			else if (r < 95)
				n = $urandom_range(17, brpc_pkg::MAX_ELEMENTS - 1);
			else
				n = brpc_pkg::MAX_ELEMENTS;
			write_set_size(n);
			no_idle = (phase % 5 == 3);
			phase_rows = rows_sent;
			while (rows_sent - phase_rows < PHASE_ROWS) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					send_row(brpc_pkg::IDX_W'($urandom_range(0, brpc_pkg::MAX_ELEMENTS - 1)),
						$urandom, 1'b0);
				else if (r < 18 && (rows_written & size_mask(n)) == size_mask(n))
					send_partial_frame(n);
				else
					send_frame(n);
				if ($urandom_range(0, 19) == 0)
					wait_drained();
			end
			no_idle = 1'b0;
			phase++;
		end
	endtask

	// result sink: random stalls, plus the long hold-off on request
	initial begin : result_sink
		int stall_left, hold_left;
		stall_left = 0;
		hold_left  = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				m_tready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_tready = 1'b0;
				stall_left--;
			end else begin
				m_tready = 1'b1;
				if (!no_idle && $urandom_range(0, 3) == 0)
					stall_left = pick_gap();
			end
		end
	end

	// compare each result transaction with the oldest pending verdict
	initial begin : verdict_monitor
		verdict_t got, want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = m_tdata[brpc_pkg::OUT_W-1:0];
				if (pending_verdicts.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("unexpected classification %b with no row marked last", got);
				end else begin
					want = pending_verdicts.pop_front();
					verdicts_checked++;
					if (want.equiv)
						seen_equiv++;
					if (want.linear)
						seen_linear++;
					if (want.kind == KIND_STRICT)
						seen_strict++;
					if (want.atrans)
						seen_atrans++;
					if (got !== want) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("classification %0d mismatch %s: expected %b got %b",
								verdicts_checked,
								"(linear,kind,order,equiv,tol,total,atrans,trans,asym,sym,arefl,refl)",
								want, got);
					end
				end
			end
		end
	end

	// stop the run when no transaction moves for too long
	initial begin : watchdog
		int stuck_cycles;
		stuck_cycles = 0;
		while (stuck_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
		end
		$display("no transaction for %0d cycles, %0d classifications pending",
			WATCHDOG_LIMIT, pending_verdicts.size());
		$display("binary_relation_property_checker_tb: done, errors");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_set();
		test_single_element();
		test_pair_extremes();
		test_three_element_shapes();
		test_output_stall();
		test_random_frames();

		wait_drained();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (pending_verdicts.size() != 0)
			errors++;

		$display("covered %0d rows and %0d classifications, set sizes 0 to %0d, %s",
			rows_sent, verdicts_checked, brpc_pkg::MAX_ELEMENTS,
			"random stalls and a long output hold-off");
		$display("relations seen: %0d equivalences, %0d linear orders, %0d strict orders, %0d %s",
			seen_equiv, seen_linear, seen_strict, seen_atrans, "antitransitive");
		if (errors == 0)
			$display("binary_relation_property_checker_tb: done, clean");
		else
			$display("binary_relation_property_checker_tb: done, errors");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/brpc_pkg.sv
rtl/brpc_lane.sv
rtl/brpc_ctrl.sv
rtl/brpc_merge.sv
rtl/binary_relation_property_checker.sv
rtl/brpc_checker.sv
tb/binary_relation_property_checker_tb.sv
